FILE: design/pls_pkg.sv
package pls_pkg;

   // default geometry
   localparam int PLS_FRAC_BITS = 2;
   localparam int PLS_POS_WIDTH = 13;

   // command and target widths
   localparam int OPCODE_W = 3;
   localparam int TARGET_W = 16;
   localparam int PEN_W    = 9;

   // control and status registers
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 12;
   localparam int REACH_W     = 12;
   localparam int LIFT_W      = 8;

   localparam logic [CSR_INDEX_W-1:0] CSR_REACH_LIMIT    = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PEN_LIFT_STEPS = 1'b1;

   localparam logic [REACH_W-1:0] REACH_LIMIT_RESET    = 12'd1500;
   localparam logic [LIFT_W-1:0]  PEN_LIFT_STEPS_RESET = 8'd16;

   typedef enum logic [OPCODE_W-1:0] {
      OP_MOVE       = 3'd0,
      OP_TICK       = 3'd1,
      OP_PEN_UP     = 3'd2,
      OP_PEN_DOWN   = 3'd3,
      OP_NUDGE_UP   = 3'd4,
      OP_NUDGE_DOWN = 3'd5
   } opcode_type;

   typedef enum logic {
      KIND_STEP = 1'b0,
      KIND_PEN  = 1'b1
   } kind_type;

endpackage

FILE: design/pls_if.sv
interface pls_req_if
   import pls_pkg::*;
   ();
   logic                       valid;
   logic                       ready;
   logic [OPCODE_W-1:0]        opcode;
   logic signed [TARGET_W-1:0] target_x;
   logic signed [TARGET_W-1:0] target_y;

   modport source (output valid, opcode, target_x, target_y, input ready);
   modport sink (input valid, opcode, target_x, target_y, output ready);
endinterface

interface pls_rsp_if
   import pls_pkg::*;
   #(parameter int POS_WIDTH = PLS_POS_WIDTH)
   ();
   logic                    valid;
   logic                    ready;
   logic                    kind;
   logic [POS_WIDTH-1:0]    pos_x;
   logic [POS_WIDTH-1:0]    pos_y;
   logic signed [PEN_W-1:0] pen_delta;
   logic                    last;

   modport source (output valid, kind, pos_x, pos_y, pen_delta, last, input ready);
   modport sink (input valid, kind, pos_x, pos_y, pen_delta, last, output ready);
endinterface

FILE: design/plotter_line_stepper.sv
// plotter line stepper: two-axis carriage and pen command engine
// req_chan takes commands (move to, tick, pen up/down, pen nudge); rsp_chan gives
// carriage steps and pen motor moves, at most one per command, in command order
// a move clamps and scales its target into the goal and gives no transaction; each
// later tick gives one quarter step on x or y until the goal, the final one marked last
// csr_we/csr_index/csr_wdata write reach_limit and pen_lift_steps; the user must do so
// only while idle, as the block does not enforce it
// throughput: one command per cycle, unless stalled; the target scaling sits ahead of the
// input register and the tick's error update between it and the output register
// stall: the output register holds its transaction while rsp ready is low; the input
// register still takes one more command, then req ready drops until the output drains
// reset (synchronous, active high): carriage at origin, pen up, no line running,
// registers back to reach_limit 1500 and pen_lift_steps 16
module plotter_line_stepper
   import pls_pkg::*;
   #(
      parameter int FRAC_BITS = PLS_FRAC_BITS,
      parameter int POS_WIDTH = PLS_POS_WIDTH
   )
   (
      input  logic                   clock,
      input  logic                   reset,
      pls_req_if.sink                req_chan,
      pls_rsp_if.source              rsp_chan,
      input  logic                   csr_we,
      input  logic [CSR_INDEX_W-1:0] csr_index,
      input  logic [CSR_DATA_W-1:0]  csr_wdata
   );

   // scaling: q = (t * (8 << frac) + 3) / 6 = (t * (4 << frac) + 1) / 3
   localparam int NW    = REACH_W + FRAC_BITS + 2;       // width of scaled numerator
   localparam int SH    = NW + 1;                        // reciprocal shift
   localparam longint RECIP = ((longint'(1) << SH) + 2) / 3;
   localparam int PW    = 2 * NW + 1;                    // product width
   localparam int CW    = NW + POS_WIDTH;                // saturation compare width
   localparam int DW    = POS_WIDTH + 1;                 // signed delta width
   localparam int EW    = 2 * POS_WIDTH + 4;             // line error width
   localparam int CPW   = POS_WIDTH + 2;                 // candidate width, room past both ends

   localparam logic [POS_WIDTH-1:0] POS_MAX = '1;

   function automatic logic [POS_WIDTH-1:0] scale_target(
      input logic signed [TARGET_W-1:0] raw,
      input logic [REACH_W-1:0]         lim
   );
      logic [REACH_W-1:0] t;
      logic [NW-1:0]      n;
      logic [PW-1:0]      prod;
      logic [NW-1:0]      q;
      if (raw < 0)
         t = '0;
      else if (raw > $signed({{(TARGET_W-REACH_W){1'b0}}, lim}))
         t = lim;
      else
         t = raw[REACH_W-1:0];
      n    = {t, {(FRAC_BITS+2){1'b0}}} | NW'(1);
      prod = PW'(n) * PW'(RECIP);
      q    = prod[SH +: NW];
      if (CW'(q) > CW'(POS_MAX))
         return POS_MAX;
      else
         return POS_WIDTH'(q);
   endfunction

   // configuration
   logic [REACH_W-1:0] reach_limit_ff;
   logic [LIFT_W-1:0]  pen_lift_steps_ff;

   // input register: command with its goal already scaled
   logic                 in_valid_ff, in_valid_in;
   logic [OPCODE_W-1:0]  in_op_ff;
   logic [POS_WIDTH-1:0] in_goal_x_ff, in_goal_y_ff;

   // line state
   logic [POS_WIDTH-1:0] cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   logic [POS_WIDTH-1:0] goal_x_ff, goal_x_in, goal_y_ff, goal_y_in;
   logic signed [DW-1:0] delta_x_ff, delta_x_in, delta_y_ff, delta_y_in;
   logic                 step_sign_x_ff, step_sign_x_in, step_sign_y_ff, step_sign_y_in;
   logic signed [EW-1:0] line_error_ff, line_error_in;
   logic                 busy_ff, busy_in;
   logic                 pen_is_down_ff, pen_is_down_in;

   // output register
   logic                    rsp_valid_ff, rsp_valid_in;
   kind_type                rsp_kind_ff, rsp_kind_in;
   logic [POS_WIDTH-1:0]    rsp_pos_x_ff, rsp_pos_y_ff;
   logic signed [PEN_W-1:0] rsp_pen_ff, rsp_pen_in;
   logic                    rsp_last_ff, rsp_last_in;
   logic                    rsp_load;

   // datapath
   logic                  advance;
   logic signed [DW-1:0]  new_dx, new_dy;
   logic signed [EW:0]    e1, e2, mag1, mag2;
   logic                  take_x;
   logic signed [CPW-1:0] px, py, gx, gy;
   logic                  over;

   // the command in the input register moves on when the output slot is free or freeing
   assign advance        = in_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;
   assign in_valid_in    = req_chan.valid ? 1'b1 : (in_valid_ff && !advance);

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.kind      = rsp_kind_ff;
   assign rsp_chan.pos_x     = rsp_pos_x_ff;
   assign rsp_chan.pos_y     = rsp_pos_y_ff;
   assign rsp_chan.pen_delta = rsp_pen_ff;
   assign rsp_chan.last      = rsp_last_ff;

   // move: delta from the present position to the new goal
   assign new_dx = $signed({1'b0, in_goal_x_ff}) - $signed({1'b0, cur_x_ff});
   assign new_dy = $signed({1'b0, in_goal_y_ff}) - $signed({1'b0, cur_y_ff});

   // tick: cross-product error of both candidate points, smaller one wins, tie to y
   assign e1 = EW'(line_error_ff) + (step_sign_x_ff ? -(EW+1)'(delta_y_ff)
                                                     : (EW+1)'(delta_y_ff));
   assign e2 = EW'(line_error_ff) - (step_sign_y_ff ? -(EW+1)'(delta_x_ff)
                                                     : (EW+1)'(delta_x_ff));
   assign mag1   = (e1 < 0) ? -e1 : e1;
   assign mag2   = (e2 < 0) ? -e2 : e2;
   assign take_x = mag1 < mag2;

   // candidates carry two spare bits so a step past either end of the range stays ordered
   assign gx = $signed({2'b00, goal_x_ff});
   assign gy = $signed({2'b00, goal_y_ff});
   assign px = $signed({2'b00, cur_x_ff})
               + (take_x ? (step_sign_x_ff ? -CPW'(1) : CPW'(1)) : CPW'(0));
   assign py = $signed({2'b00, cur_y_ff})
               + (take_x ? CPW'(0) : (step_sign_y_ff ? -CPW'(1) : CPW'(1)));
   // candidate past the goal on either axis
   assign over = (step_sign_x_ff ? (px < gx) : (px > gx))
              || (step_sign_y_ff ? (py < gy) : (py > gy));

   always_comb begin
      cur_x_in       = cur_x_ff;
      cur_y_in       = cur_y_ff;
      goal_x_in      = goal_x_ff;
      goal_y_in      = goal_y_ff;
      delta_x_in     = delta_x_ff;
      delta_y_in     = delta_y_ff;
      step_sign_x_in = step_sign_x_ff;
      step_sign_y_in = step_sign_y_ff;
      line_error_in  = line_error_ff;
      busy_in        = busy_ff;
      pen_is_down_in = pen_is_down_ff;
      rsp_load       = 1'b0;
      rsp_kind_in    = KIND_STEP;
      rsp_pen_in     = '0;
      rsp_last_in    = 1'b0;
      if (advance) begin
         case (in_op_ff)
            OP_MOVE: begin
               goal_x_in      = in_goal_x_ff;
               goal_y_in      = in_goal_y_ff;
               delta_x_in     = new_dx;
               delta_y_in     = new_dy;
               step_sign_x_in = !(cur_x_ff < in_goal_x_ff);
               step_sign_y_in = !(cur_y_ff < in_goal_y_ff);
               line_error_in  = '0;
               busy_in        = (new_dx != 0) || (new_dy != 0);
            end
            OP_TICK: begin
               if (busy_ff) begin
                  rsp_load = 1'b1;
                  if (over) begin
                     // final exact move onto the goal
                     cur_x_in    = goal_x_ff;
                     cur_y_in    = goal_y_ff;
                     busy_in     = 1'b0;
                     rsp_last_in = 1'b1;
                  end else begin
                     cur_x_in      = px[POS_WIDTH-1:0];
                     cur_y_in      = py[POS_WIDTH-1:0];
                     line_error_in = take_x ? e1[EW-1:0] : e2[EW-1:0];
                  end
               end
            end
            OP_PEN_UP: begin
               if (pen_is_down_ff) begin
                  pen_is_down_in = 1'b0;
                  rsp_load       = 1'b1;
                  rsp_kind_in    = KIND_PEN;
                  rsp_pen_in     = PEN_W'(0) - $signed({1'b0, pen_lift_steps_ff});
               end
            end
            OP_PEN_DOWN: begin
               if (!pen_is_down_ff) begin
                  pen_is_down_in = 1'b1;
                  rsp_load       = 1'b1;
                  rsp_kind_in    = KIND_PEN;
                  rsp_pen_in     = $signed({1'b0, pen_lift_steps_ff});
               end
            end
            OP_NUDGE_UP: begin
               rsp_load    = 1'b1;
               rsp_kind_in = KIND_PEN;
               rsp_pen_in  = PEN_W'(1);
            end
            OP_NUDGE_DOWN: begin
               rsp_load    = 1'b1;
               rsp_kind_in = KIND_PEN;
               rsp_pen_in  = -PEN_W'(1);
            end
            default: begin
               rsp_load = 1'b0;
            end
         endcase
      end
      rsp_valid_in = rsp_load ? 1'b1 : (rsp_valid_ff && !rsp_chan.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         reach_limit_ff    <= REACH_LIMIT_RESET;
         pen_lift_steps_ff <= PEN_LIFT_STEPS_RESET;
         in_valid_ff       <= 1'b0;
         cur_x_ff          <= '0;
         cur_y_ff          <= '0;
         goal_x_ff         <= '0;
         goal_y_ff         <= '0;
         delta_x_ff        <= '0;
         delta_y_ff        <= '0;
         step_sign_x_ff    <= 1'b0;
         step_sign_y_ff    <= 1'b0;
         line_error_ff     <= '0;
         busy_ff           <= 1'b0;
         pen_is_down_ff    <= 1'b0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_REACH_LIMIT:    reach_limit_ff    <= csr_wdata[REACH_W-1:0];
               CSR_PEN_LIFT_STEPS: pen_lift_steps_ff <= csr_wdata[LIFT_W-1:0];
               default:            reach_limit_ff    <= reach_limit_ff;
            endcase
         end
         in_valid_ff    <= in_valid_in;
         cur_x_ff       <= cur_x_in;
         cur_y_ff       <= cur_y_in;
         goal_x_ff      <= goal_x_in;
         goal_y_ff      <= goal_y_in;
         delta_x_ff     <= delta_x_in;
         delta_y_ff     <= delta_y_in;
         step_sign_x_ff <= step_sign_x_in;
         step_sign_y_ff <= step_sign_y_in;
         line_error_ff  <= line_error_in;
         busy_ff        <= busy_in;
         pen_is_down_ff <= pen_is_down_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         in_op_ff     <= req_chan.opcode;
         in_goal_x_ff <= scale_target(req_chan.target_x, reach_limit_ff);
         in_goal_y_ff <= scale_target(req_chan.target_y, reach_limit_ff);
      end
      if (rsp_load) begin
         rsp_kind_ff  <= rsp_kind_in;
         rsp_pos_x_ff <= cur_x_in;
         rsp_pos_y_ff <= cur_y_in;
         rsp_pen_ff   <= rsp_pen_in;
         rsp_last_ff  <= rsp_last_in;
      end
   end

endmodule
